[design/qau_pkg.sv]
// shared types, constants and helpers for the quaternion arithmetic unit
`timescale 1ns / 1ps
package qau_pkg;

  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 24;

  localparam int PROD_W     = 2 * COMP_WIDTH;
  localparam int SUM_W      = 2 * COMP_WIDTH + 2;
  localparam int ROOT_BITS  = COMP_WIDTH - 1;
  localparam int SQ_STEP    = 4;
  localparam int SQ_STAGES  = (ROOT_BITS + SQ_STEP - 1) / SQ_STEP;
  localparam int ROOT_W     = SQ_STAGES * SQ_STEP;
  localparam int ROOT_PAD   = ROOT_W - ROOT_BITS;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int REM_W      = ROOT_W + 3;
  localparam int IN_DATA_W  = ((8 * COMP_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((4 * COMP_WIDTH + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_MUL  = 2'd1,
    OP_CONJ = 2'd2,
    OP_NORM = 2'd3
  } op_e;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic [3:0][COMP_WIDTH-1:0] quat_t;
  typedef logic signed [SUM_W-1:0] wide_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam comp_t COMP_MAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  typedef struct packed {
    comp_t val;
    logic  ov;
  } sat_t;

  typedef struct packed {
    logic  valid;
    op_e   op;
    quat_t q;
    logic  ov;
  } ctl_t;

  typedef struct packed {
    wide_t w;
    wide_t x;
    wide_t y;
    wide_t z;
  } wsum_t;

  typedef struct packed {
    logic              valid;
    op_e               op;
    quat_t             res;
    logic              ov;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  function automatic sat_t sat_comp(input wide_t v);
    sat_t r;
    r.ov  = 1'b0;
    r.val = v[COMP_WIDTH-1:0];
    if (v[SUM_W-1:COMP_WIDTH-1] != {(SUM_W-COMP_WIDTH+1){v[COMP_WIDTH-1]}}) begin
      r.ov  = 1'b1;
      r.val = v[SUM_W-1] ? COMP_MIN : COMP_MAX;
    end
    return r;
  endfunction

endpackage

[design/qau_prod.sv]
// partial products, add and conjugate, then product sums
`timescale 1ns / 1ps
module qau_prod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  qau_pkg::op_e    op_i,
  input  qau_pkg::quat_t  a_i,
  input  qau_pkg::quat_t  b_i,
  output qau_pkg::ctl_t   ctl_o,
  output qau_pkg::wsum_t  sum_o
);

  qau_pkg::quat_t bop;
  qau_pkg::prod_t p_d [4][4];
  qau_pkg::prod_t p_q [4][4];
  qau_pkg::ctl_t  ctl1_d, ctl1_q, ctl2_q;
  qau_pkg::wsum_t sum_d, sum_q;
  qau_pkg::sat_t  s [4];

  assign bop = (op_i == qau_pkg::OP_NORM) ? a_i : b_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_d[i][j] = qau_pkg::prod_t'($signed(a_i[i])) * qau_pkg::prod_t'($signed(bop[j]));
      end
    end
  end

  always_comb begin
    ctl1_d.valid = valid_i;
    ctl1_d.op    = op_i;
    ctl1_d.ov    = 1'b0;
    ctl1_d.q     = '0;
    for (int i = 0; i < 4; i++) begin
      if (op_i == qau_pkg::OP_CONJ) begin
        s[i] = qau_pkg::sat_comp(-qau_pkg::wide_t'($signed(a_i[i])));
      end else begin
        s[i] = qau_pkg::sat_comp(qau_pkg::wide_t'($signed(a_i[i]))
                                 + qau_pkg::wide_t'($signed(b_i[i])));
      end
    end
    if (op_i == qau_pkg::OP_ADD) begin
      for (int i = 0; i < 4; i++) begin
        ctl1_d.q[i] = s[i].val;
      end
      ctl1_d.ov = s[0].ov | s[1].ov | s[2].ov | s[3].ov;
    end else if (op_i == qau_pkg::OP_CONJ) begin
      ctl1_d.q[0] = a_i[0];
      for (int i = 1; i < 4; i++) begin
        ctl1_d.q[i] = s[i].val;
      end
      ctl1_d.ov = s[1].ov | s[2].ov | s[3].ov;
    end
  end

  always_comb begin
    if (ctl1_q.op == qau_pkg::OP_NORM) begin
      sum_d.w = qau_pkg::wide_t'(p_q[0][0]) + qau_pkg::wide_t'(p_q[1][1])
              + qau_pkg::wide_t'(p_q[2][2]) + qau_pkg::wide_t'(p_q[3][3]);
    end else begin
      sum_d.w = qau_pkg::wide_t'(p_q[0][0]) - qau_pkg::wide_t'(p_q[1][1])
              - qau_pkg::wide_t'(p_q[2][2]) - qau_pkg::wide_t'(p_q[3][3]);
    end
    sum_d.x = qau_pkg::wide_t'(p_q[0][1]) + qau_pkg::wide_t'(p_q[1][0])
            + qau_pkg::wide_t'(p_q[2][3]) - qau_pkg::wide_t'(p_q[3][2]);
    sum_d.y = qau_pkg::wide_t'(p_q[0][2]) + qau_pkg::wide_t'(p_q[2][0])
            + qau_pkg::wide_t'(p_q[3][1]) - qau_pkg::wide_t'(p_q[1][3]);
    sum_d.z = qau_pkg::wide_t'(p_q[0][3]) + qau_pkg::wide_t'(p_q[3][0])
            + qau_pkg::wide_t'(p_q[1][2]) - qau_pkg::wide_t'(p_q[2][1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q.valid <= 1'b0;
      ctl2_q.valid <= 1'b0;
    end else if (en_i) begin
      ctl1_q <= ctl1_d;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= p_d;
      sum_q <= sum_d;
    end
  end

  assign ctl_o = ctl2_q;
  assign sum_o = sum_q;

endmodule

[design/qau_round.sv]
// rounding and saturation of product sums, norm radicand setup
`timescale 1ns / 1ps
module qau_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  qau_pkg::ctl_t  ctl_i,
  input  qau_pkg::wsum_t sum_i,
  output qau_pkg::sq_t   sq_o
);

  localparam qau_pkg::wide_t RND_HALF = qau_pkg::wide_t'(1) << (qau_pkg::FRAC_BITS - 1);

  qau_pkg::wide_t rnd [4];
  qau_pkg::sat_t  s [4];
  qau_pkg::sq_t   sq_d, sq_q;
  logic           big;

  always_comb begin
    rnd[0] = (sum_i.w + RND_HALF) >>> qau_pkg::FRAC_BITS;
    rnd[1] = (sum_i.x + RND_HALF) >>> qau_pkg::FRAC_BITS;
    rnd[2] = (sum_i.y + RND_HALF) >>> qau_pkg::FRAC_BITS;
    rnd[3] = (sum_i.z + RND_HALF) >>> qau_pkg::FRAC_BITS;
    for (int i = 0; i < 4; i++) begin
      s[i] = qau_pkg::sat_comp(rnd[i]);
    end
  end

  assign big = |sum_i.w[qau_pkg::SUM_W-1:2*qau_pkg::ROOT_BITS];

  always_comb begin
    sq_d.valid = ctl_i.valid;
    sq_d.op    = ctl_i.op;
    sq_d.rem   = '0;
    sq_d.root  = '0;
    sq_d.rad   = {sum_i.w[2*qau_pkg::ROOT_BITS-1:0], {(2*qau_pkg::ROOT_PAD){1'b0}}};
    sq_d.res   = ctl_i.q;
    sq_d.ov    = ctl_i.ov;
    unique case (ctl_i.op)
      qau_pkg::OP_MUL: begin
        for (int i = 0; i < 4; i++) begin
          sq_d.res[i] = s[i].val;
        end
        sq_d.ov = s[0].ov | s[1].ov | s[2].ov | s[3].ov;
      end
      qau_pkg::OP_NORM: begin
        sq_d.res    = '0;
        sq_d.res[0] = big ? qau_pkg::COMP_MAX : '0;
        sq_d.ov     = big;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q.valid <= 1'b0;
    end else if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

[design/qau_sqrt_stage.sv]
// one registered stage of the digit-by-digit square root
`timescale 1ns / 1ps
module qau_sqrt_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  qau_pkg::sq_t sq_i,
  output qau_pkg::sq_t sq_o
);

  qau_pkg::sq_t             sq_d, sq_q;
  logic [qau_pkg::REM_W-1:0] rem_n;
  logic [qau_pkg::REM_W-1:0] trial;

  always_comb begin
    sq_d  = sq_i;
    rem_n = '0;
    trial = '0;
    for (int k = 0; k < qau_pkg::SQ_STEP; k++) begin
      rem_n    = {sq_d.rem[qau_pkg::REM_W-3:0], sq_d.rad[qau_pkg::RAD_W-1 -: 2]};
      trial    = {1'b0, sq_d.root, 2'b01};
      sq_d.rad = sq_d.rad << 2;
      if (rem_n >= trial) begin
        sq_d.rem  = rem_n - trial;
        sq_d.root = {sq_d.root[qau_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        sq_d.rem  = rem_n;
        sq_d.root = {sq_d.root[qau_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q.valid <= 1'b0;
    end else if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

[design/quaternion_arithmetic_unit.sv]
// every operation passes through the product, sum, rounding and square-root registers in that order
// throughput: one request per cycle while the output is not stalled; the whole pipe advances when the output is free
// the depth is set by the square root, four root bits per stage
// a stalled output holds all stages; nothing is dropped or repeated
// reset clears all valid bits asynchronously; data registers are not reset
`timescale 1ns / 1ps
module quaternion_arithmetic_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
  input  logic [qau_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // r_w, r_x, r_y, r_z
  output logic [qau_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // overflow
  output logic                           m_axis_tuser
);

  logic           en;
  qau_pkg::quat_t a, b, r;
  qau_pkg::ctl_t  ctl;
  qau_pkg::wsum_t sum;
  qau_pkg::sq_t   chain [qau_pkg::SQ_STAGES+1];
  qau_pkg::sq_t   last;

  assign en = !last.valid || m_axis_tready;
  assign s_axis_tready = en;

  assign a = s_axis_tdata[4*qau_pkg::COMP_WIDTH-1:0];
  assign b = s_axis_tdata[8*qau_pkg::COMP_WIDTH-1:4*qau_pkg::COMP_WIDTH];

  qau_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .op_i    (qau_pkg::op_e'(s_axis_tuser)),
    .a_i     (a),
    .b_i     (b),
    .ctl_o   (ctl),
    .sum_o   (sum)
  );

  qau_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl),
    .sum_i  (sum),
    .sq_o   (chain[0])
  );

  for (genvar g = 0; g < qau_pkg::SQ_STAGES; g++) begin : g_sqrt
    qau_sqrt_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sq_i   (chain[g]),
      .sq_o   (chain[g+1])
    );
  end

  assign last = chain[qau_pkg::SQ_STAGES];

  always_comb begin
    r = last.res;
    if (last.op == qau_pkg::OP_NORM && !last.ov) begin
      r[0] = qau_pkg::COMP_WIDTH'(last.root[qau_pkg::ROOT_W-1:qau_pkg::ROOT_PAD]);
    end
  end

  assign m_axis_tvalid = last.valid;
  assign m_axis_tdata  = qau_pkg::OUT_DATA_W'(r);
  assign m_axis_tuser  = last.ov;

`ifndef NO_ASSERTIONS
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  a_norm_vector_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && last.op == qau_pkg::OP_NORM) |-> (r[1] == '0 && r[2] == '0 && r[3] == '0))
    else $error("norm result has nonzero vector part");

  a_ov_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && last.ov) |->
      (r[0] == qau_pkg::COMP_MAX || r[0] == qau_pkg::COMP_MIN ||
       r[1] == qau_pkg::COMP_MAX || r[1] == qau_pkg::COMP_MIN ||
       r[2] == qau_pkg::COMP_MAX || r[2] == qau_pkg::COMP_MIN ||
       r[3] == qau_pkg::COMP_MAX || r[3] == qau_pkg::COMP_MIN))
    else $error("overflow flag without a saturated component");

  a_stall_holds_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(chain[0].valid))
    else $error("pipeline moved during a stall");
`endif

endmodule
